/* src/lru_move_to_front_cache_macros.svh */
// Assertion macros shared by the cache RTL.
`ifndef LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH
`define LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LMTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmtf: assertion failed");

// Next-cycle implication, checked outside reset.
`define LMTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmtf: assertion failed");

`endif

/* src/lmtf_pkg.sv */
// Package: sizes shared by the move-to-front cache files.
package lmtf_pkg;
	localparam int CACHE_DEPTH = 256;
	localparam int IDX_W       = $clog2(CACHE_DEPTH);
	localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);
	localparam int COLOR_W     = 48;
	localparam int TILE_W      = 32;
endpackage

/* src/lmtf_if.sv */
// Request and response channel interfaces of the move-to-front cache.
interface lmtf_req_if;
	import lmtf_pkg::*;
	logic               valid;
	logic               ready;
	logic               action;
	logic [COLOR_W-1:0] color_key;
	logic [TILE_W-1:0]  tile_handle;
	modport source (output valid, action, color_key, tile_handle, input ready);
	modport sink   (input valid, action, color_key, tile_handle, output ready);
endinterface

interface lmtf_rsp_if;
	import lmtf_pkg::*;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [COLOR_W-1:0] color_out;
	logic [TILE_W-1:0]  tile_out;
	modport source (output valid, hit, color_out, tile_out, input ready);
	modport sink   (input valid, hit, color_out, tile_out, output ready);
endinterface

/* src/lru_move_to_front_cache.sv */
// Top level: fully associative move-to-front cache of color/tile pairs.
// Each request transaction looks up a color (action 0) or a tile handle
// (action 1) by walking the recency chain from the head, one link per clock
// through the single read port of the entry memories and one shared key
// comparator. A hit on the front entry goes straight to the result; a hit
// further back adds a relink step for the second link write, a miss an insert
// step. Ready returns on the edge that loads the result, so the next request
// can be taken in the cycle that follows. Worst case is a full-cache miss. The
// request channel is ready only while the sequencer is idle; the response sits
// in an output register, so a new request is taken while an earlier result
// waits. A finished request whose output register is still held waits in the
// sequencer until the response transaction goes out. Entry memories need no
// clearing after reset: only slots below the fill count are ever read.
`include "lru_move_to_front_cache_macros.svh"

module lru_move_to_front_cache (
	input  logic      clk,
	input  logic      arst_n,
	lmtf_req_if.sink   req,
	lmtf_rsp_if.source rsp
);
	import lmtf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WALK   = 5'b00010,
		ST_RELINK = 5'b00100,
		ST_MISS   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// control state
	state_t           state_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	// per-request working registers
	logic               action_q;
	logic [COLOR_W-1:0] key_color_q;
	logic [TILE_W-1:0]  key_tile_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   prev_q;
	logic [CNT_W-1:0]   seen_q;
	logic               hit_q;
	logic [COLOR_W-1:0] res_color_q;
	logic [TILE_W-1:0]  res_tile_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [TILE_W-1:0]  out_tile_q;
	logic               out_hit_q;

	// memory ports
	logic [IDX_W-1:0]   rd_addr;
	logic [COLOR_W-1:0] color_rd;
	logic [TILE_W-1:0]  tile_rd;
	logic [IDX_W-1:0]   next_rd;
	logic               pair_we;
	logic [IDX_W-1:0]   pair_waddr;
	logic               next_we;
	logic [IDX_W-1:0]   next_waddr;
	logic [IDX_W-1:0]   next_wdata;

	logic             req_fire;
	logic             key_match;
	logic             last_step;
	logic             not_full;
	logic [IDX_W-1:0] ins_idx;
	logic [IDX_W-1:0] ins_next;
	logic             out_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// shared comparator: one chain entry per clock
	assign key_match = action_q ? (tile_rd == key_tile_q) : (color_rd == key_color_q);
	assign last_step = ((seen_q + CNT_W'(1)) == count_q);
	assign not_full  = (count_q < CNT_W'(CACHE_DEPTH));

	// miss insert slot: next free slot while filling, else the tail
	assign ins_idx  = not_full ? count_q[IDX_W-1:0] : prev_q;
	assign ins_next = (count_q == '0) ? '0 : head_q;

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	// idle: prefetch the head; walking: follow the link just read
	assign rd_addr = (state_q == ST_IDLE) ? head_q : next_rd;

	always_comb begin
		pair_we    = 1'b0;
		pair_waddr = ins_idx;
		next_we    = 1'b0;
		next_waddr = ins_idx;
		next_wdata = ins_next;
		unique case (state_q)
			ST_WALK: begin
				// unlink the hit entry: its predecessor skips over it
				if (key_match && (seen_q != '0)) begin
					next_we    = 1'b1;
					next_waddr = prev_q;
					next_wdata = next_rd;
				end
			end
			ST_RELINK: begin
				next_we    = 1'b1;
				next_waddr = cur_q;
				next_wdata = head_q;
			end
			ST_MISS: begin
				pair_we = 1'b1;
				next_we = 1'b1;
			end
			ST_IDLE, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	lmtf_ram #(.WIDTH(COLOR_W), .DEPTH(CACHE_DEPTH)) u_color_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (key_color_q),
		.raddr (rd_addr),
		.rdata (color_rd)
	);

	lmtf_ram #(.WIDTH(TILE_W), .DEPTH(CACHE_DEPTH)) u_tile_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (key_tile_q),
		.raddr (rd_addr),
		.rdata (tile_rd)
	);

	lmtf_ram #(.WIDTH(IDX_W), .DEPTH(CACHE_DEPTH)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	// sequencer and cache bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= (count_q == '0) ? ST_MISS : ST_WALK;
					end
				end
				ST_WALK: begin
					if (key_match) begin
						state_q <= (seen_q == '0) ? ST_FINISH : ST_RELINK;
					end else if (last_step) begin
						state_q <= ST_MISS;
					end
				end
				ST_RELINK: begin
					head_q  <= cur_q;
					state_q <= ST_FINISH;
				end
				ST_MISS: begin
					head_q <= ins_idx;
					if (not_full) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_q    <= req.action;
			key_color_q <= req.color_key;
			key_tile_q  <= req.tile_handle;
			cur_q       <= head_q;
			prev_q      <= '0;
			seen_q      <= '0;
			hit_q       <= 1'b0;
		end
		if (state_q == ST_WALK) begin
			if (key_match) begin
				hit_q       <= 1'b1;
				res_color_q <= color_rd;
				res_tile_q  <= tile_rd;
			end else begin
				prev_q <= cur_q;
				cur_q  <= next_rd;
				seen_q <= seen_q + CNT_W'(1);
			end
		end
		if (state_q == ST_MISS) begin
			res_color_q <= key_color_q;
			res_tile_q  <= key_tile_q;
		end
		if (out_load) begin
			out_hit_q   <= hit_q;
			out_color_q <= res_color_q;
			out_tile_q  <= res_tile_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.color_out = out_color_q;
	assign rsp.tile_out  = out_tile_q;

	`LMTF_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CACHE_DEPTH))
	`LMTF_ASSERT_NOW(a_walk_in_range, clk, arst_n, state_q == ST_WALK, seen_q < count_q)
	`LMTF_ASSERT_NEXT(a_empty_goes_miss, clk, arst_n, req_fire && (count_q == '0), state_q == ST_MISS)
	`LMTF_ASSERT_NEXT(a_relink_head, clk, arst_n, state_q == ST_RELINK, head_q == $past(cur_q))
	`LMTF_ASSERT_NEXT(a_finish_valid, clk, arst_n, out_load, out_valid_q && (state_q == ST_IDLE))
endmodule

/* src/lmtf_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module lmtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* bench/tb_lru_move_to_front_cache.sv */
// Testbench for the move-to-front color/tile cache: directed and random lookups.
`timescale 1ns / 100ps

// Stimulus is queued up front and fed by a clocked driver that leaves random
// gaps between transactions. A software copy of the recency chain is updated
// at every accepted request and yields the front pair that the cache must
// return. A clocked monitor stalls the response channel at random and checks
// each response transaction against the oldest pending prediction.
module tb_lru_move_to_front_cache;
	import lmtf_pkg::*;

	typedef enum logic {
		BY_COLOR = 1'b0,
		BY_TILE  = 1'b1
	} lookup_kind_t;

	typedef struct packed {
		lookup_kind_t       kind;
		logic [COLOR_W-1:0] color;
		logic [TILE_W-1:0]  tile;
	} lookup_req_t;

	typedef struct packed {
		logic               hit;
		logic [COLOR_W-1:0] color;
		logic [TILE_W-1:0]  tile;
	} front_pair_t;

	localparam int RANDOM_ITEMS = 1900;
	localparam int POOL_MAX     = 320;   // a bit more than the cache holds

	logic clk;
	logic arst_n;

	lmtf_req_if req_ch ();
	lmtf_rsp_if rsp_ch ();

	lru_move_to_front_cache dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Software copy of the cache: slot contents, recency links, head, fill.
	logic [COLOR_W-1:0] slot_color [CACHE_DEPTH];
	logic [TILE_W-1:0]  slot_tile  [CACHE_DEPTH];
	logic [IDX_W-1:0]   slot_link  [CACHE_DEPTH];
	logic [IDX_W-1:0]   mru_slot;
	int unsigned        fill_count;

	lookup_req_t        pending_reqs [$];
	front_pair_t        front_q      [$];
	logic [COLOR_W-1:0] color_pool   [$];
	logic [TILE_W-1:0]  tile_pool    [$];

	int unsigned n_total;
	int unsigned n_accepted;
	int unsigned n_errors;

	// driver / monitor pacing
	lookup_req_t cur_req;
	int unsigned gap_cnt;
	int unsigned stall_cnt;
	bit          drv_calm;
	bit          mon_calm;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_errors++;
	endtask

	// Walk the chain from the most recent slot, promote or insert, and
	// return the pair that ends up at the front.
	function automatic front_pair_t mtf_lookup(input lookup_req_t rq);
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] prev;
		int unsigned      walked;
		logic             found;
		front_pair_t      res;
		cur    = mru_slot;
		prev   = '0;
		walked = 0;
		found  = 1'b0;
		while (walked < fill_count && !found) begin
			if (rq.kind == BY_TILE ? slot_tile[cur] == rq.tile : slot_color[cur] == rq.color)
				found = 1'b1;
			else begin
				prev = cur;
				cur  = slot_link[cur];
				walked++;
			end
		end
		if (found) begin
			// front hit leaves the chain alone
			if (walked != 0) begin
				slot_link[prev] = slot_link[cur];
				slot_link[cur]  = mru_slot;
				mru_slot        = cur;
			end
		end else if (fill_count < CACHE_DEPTH) begin
			// fresh slots are handed out in index order
			cur             = IDX_W'(fill_count);
			slot_color[cur] = rq.color;
			slot_tile[cur]  = rq.tile;
			slot_link[cur]  = (fill_count == 0) ? '0 : mru_slot;
			mru_slot        = cur;
			fill_count++;
		end else begin
			// full: the tail (last slot walked) is recycled as the new head
			slot_color[prev] = rq.color;
			slot_tile[prev]  = rq.tile;
			slot_link[prev]  = mru_slot;
			mru_slot         = prev;
		end
		res.hit   = found;
		res.color = slot_color[mru_slot];
		res.tile  = slot_tile[mru_slot];
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long; none in calm phases.
	function automatic int unsigned idle_len(input bit calm);
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Pick a color: from the recent pool (likely a hit), an extreme, or fresh.
	function automatic logic [COLOR_W-1:0] draw_color(input int unsigned pool_pct);
		int unsigned        r;
		logic [COLOR_W-1:0] c;
		r = $urandom_range(99);
		if (r < pool_pct && color_pool.size() != 0)
			c = color_pool[$urandom_range(color_pool.size() - 1)];
		else if (r < pool_pct + 6) begin
			case ($urandom_range(2))
				0:       c = '0;
				1:       c = '1;
				default: c = COLOR_W'(1) << $urandom_range(COLOR_W - 1);
			endcase
		end else
			c = COLOR_W'({$urandom(), $urandom()});
		return c;
	endfunction

	function automatic logic [TILE_W-1:0] draw_tile(input int unsigned pool_pct);
		int unsigned       r;
		logic [TILE_W-1:0] t;
		r = $urandom_range(99);
		if (r < pool_pct && tile_pool.size() != 0)
			t = tile_pool[$urandom_range(tile_pool.size() - 1)];
		else if (r < pool_pct + 6) begin
			case ($urandom_range(2))
				0:       t = '0;
				1:       t = '1;
				default: t = TILE_W'(1) << $urandom_range(TILE_W - 1);
			endcase
		end else
			t = $urandom();
		return t;
	endfunction

	task automatic queue_lookup(input lookup_kind_t kind, input logic [COLOR_W-1:0] color,
			input logic [TILE_W-1:0] tile);
		lookup_req_t rq;
		rq.kind  = kind;
		rq.color = color;
		rq.tile  = tile;
		pending_reqs.push_back(rq);
		color_pool.push_back(color);
		tile_pool.push_back(tile);
		if (color_pool.size() > POOL_MAX)
			void'(color_pool.pop_front());
		if (tile_pool.size() > POOL_MAX)
			void'(tile_pool.pop_front());
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_lru_move_to_front_cache: done, errors");
		$finish;
	end

	// Request driver: holds valid until the transaction is taken, then waits
	// out a random gap before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.action      <= BY_COLOR;
			req_ch.color_key   <= '0;
			req_ch.tile_handle <= '0;
			gap_cnt            <= 0;
			drv_calm           <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (gap_cnt != 0) begin
				req_ch.valid <= 1'b0;
				gap_cnt      <= gap_cnt - 1;
			end else if (pending_reqs.size() != 0) begin
				cur_req             = pending_reqs.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.action      <= cur_req.kind;
				req_ch.color_key   <= cur_req.color;
				req_ch.tile_handle <= cur_req.tile;
				gap_cnt            <= idle_len(drv_calm);
				if ($urandom_range(149) == 0)
					drv_calm <= !drv_calm;
			end else
				req_ch.valid <= 1'b0;
		end
	end

	// Prediction at each accepted request (values sampled before the edge).
	always @(posedge clk) begin
		lookup_req_t rq;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			rq.kind  = lookup_kind_t'(req_ch.action);
			rq.color = req_ch.color_key;
			rq.tile  = req_ch.tile_handle;
			front_q.push_back(mtf_lookup(rq));
			n_accepted++;
		end
	end

	// Response monitor with random backpressure.
	always @(posedge clk or negedge arst_n) begin
		front_pair_t exp_pair;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_cnt    <= 0;
			mon_calm     <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (front_q.size() == 0)
					report_mismatch($sformatf("unexpected response hit=%0b color=%h tile=%h",
						rsp_ch.hit, rsp_ch.color_out, rsp_ch.tile_out));
				else begin
					exp_pair = front_q.pop_front();
					if (rsp_ch.hit !== exp_pair.hit)
						report_mismatch($sformatf("hit got %b exp %b",
							rsp_ch.hit, exp_pair.hit));
					if (rsp_ch.color_out !== exp_pair.color)
						report_mismatch($sformatf("color_out got %h exp %h",
							rsp_ch.color_out, exp_pair.color));
					if (rsp_ch.tile_out !== exp_pair.tile)
						report_mismatch($sformatf("tile_out got %h exp %h",
							rsp_ch.tile_out, exp_pair.tile));
				end
			end
			if (stall_cnt != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_cnt    <= stall_cnt - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_ch.valid && rsp_ch.ready) begin
					stall_cnt <= idle_len(mon_calm);
					if ($urandom_range(149) == 0)
						mon_calm <= !mon_calm;
				end
			end
		end
	end

	initial begin
		lookup_kind_t kind;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = BY_COLOR;
		req_ch.color_key   = '0;
		req_ch.tile_handle = '0;
		rsp_ch.ready       = 1'b0;
		mru_slot           = '0;
		fill_count         = 0;
		n_accepted         = 0;
		n_errors           = 0;

		// Directed: an empty-cache miss, field extremes, front and deeper hits.
		queue_lookup(BY_COLOR, '0, '0);                         // empty cache
		queue_lookup(BY_COLOR, '0, 32'h1111_1111);              // hit on front
		queue_lookup(BY_TILE, '1, '1);                          // miss, all ones
		queue_lookup(BY_TILE, 48'h1234_5678_9abc, '0);          // hit one back
		queue_lookup(BY_COLOR, '1, 32'h2222_2222);              // hit one back
		queue_lookup(BY_TILE, '1, '0);                          // hit one back
		// duplicate payload: stores color 0 again, later lookup takes newest
		queue_lookup(BY_TILE, '0, 32'h0000_1234);
		queue_lookup(BY_COLOR, '0, 32'hdead_beef);
		queue_lookup(BY_TILE, 48'h0, 32'h0);                    // older tile 0
		queue_lookup(BY_COLOR, 48'haaaa_aaaa_aaaa, 32'h5555_5555);
		queue_lookup(BY_TILE, 48'h5555_5555_5555, 32'haaaa_aaaa);
		queue_lookup(BY_TILE, 48'h0, 32'h5555_5555);            // hit one back
		queue_lookup(BY_COLOR, 48'h5555_5555_5555, 32'h0);      // hit
		queue_lookup(BY_COLOR, 48'h8000_0000_0000, 32'h8000_0000);
		queue_lookup(BY_TILE, 48'h0000_0000_0001, 32'h0000_0001);
		queue_lookup(BY_COLOR, 48'h8000_0000_0000, 32'h0);      // hit
		queue_lookup(BY_TILE, 48'h0, 32'hffff_ffff);            // hit at tail side
		queue_lookup(BY_COLOR, 48'h1234_5678_9abc, 32'h0);      // miss
		// duplicate tile through a color-keyed miss
		queue_lookup(BY_COLOR, 48'h0f0f_0f0f_0f0f, 32'h0000_0001);
		queue_lookup(BY_TILE, 48'h0, 32'h0000_0001);            // newest wins

		// Random: keys half from recent history, so hits, promotions and
		// full-cache recycling all show up; payloads sometimes repeat.
		repeat (RANDOM_ITEMS) begin
			kind = lookup_kind_t'($urandom_range(1));
			if (kind == BY_COLOR)
				queue_lookup(kind, draw_color(50), draw_tile(15));
			else
				queue_lookup(kind, draw_color(15), draw_tile(50));
		end
		n_total = pending_reqs.size();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (n_accepted == n_total);
		wait (front_q.size() == 0);
		repeat (300) @(posedge clk);
		if (n_errors == 0)
			$display("tb_lru_move_to_front_cache: done, clean");
		else
			$display("tb_lru_move_to_front_cache: done, errors");
		$finish;
	end
endmodule
